FILE: src/rhv_pkg.sv
package rhv_pkg;

    localparam int HOLD_W  = 32;
    localparam int FRAME_W = 64;
    localparam int FRAC_W  = 53;
    localparam int CFG_AW  = 3;

    localparam logic [63:0] MIX_ADD  = 64'h9E3779B97F4A7C15;
    localparam logic [63:0] MIX_MUL1 = 64'hBF58476D1CE4E5B9;
    localparam logic [63:0] MIX_MUL2 = 64'h94D049BB133111EB;
    localparam logic [63:0] HELD_MUL = 64'd100000;

    // configuration register indexes
    typedef enum logic [CFG_AW-1:0] {
        CFG_MIN_HOLD   = 3'd0,
        CFG_MAX_HOLD   = 3'd1,
        CFG_RESEED     = 3'd2,
        CFG_SEED_INNER = 3'd3,
        CFG_SEED_OUTER = 3'd4,
        CFG_FINAL_EN   = 3'd5
    } cfg_idx_t;

    // partial products of the low 64 bits of a 64x64 product
    typedef struct packed {
        logic [63:0] p00;
        logic [31:0] p01;
        logic [31:0] p10;
    } pp_t;

    function automatic pp_t mul_pp(input logic [63:0] a, input logic [63:0] b);
        pp_t p;
        p.p00 = 64'(a[31:0]) * 64'(b[31:0]);
        p.p01 = a[31:0] * b[63:32];
        p.p10 = a[63:32] * b[31:0];
        return p;
    endfunction

    function automatic logic [63:0] pp_sum(input pp_t p);
        logic [31:0] mid;
        mid = p.p01 + p.p10;
        return p.p00 + {mid, 32'd0};
    endfunction

endpackage

FILE: src/rhv_modpipe.sv
module rhv_modpipe
    import rhv_pkg::*;
#(
    parameter int SIDE_W = 64
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic                 in_valid,
    input  logic [63:0]          in_a,
    input  logic [HOLD_W-1:0]    in_m,
    input  logic [SIDE_W-1:0]    in_side,
    output logic                 out_valid,
    output logic [HOLD_W-1:0]    out_rem,
    output logic [SIDE_W-1:0]    out_side
);

    // two quotient bits per stage over the 64-bit magnitude
    localparam int N = 32;

    logic [N:0]             v_reg;
    logic [N:0]             neg_reg;
    logic [63:0]            dvd_reg  [N+1];
    logic [HOLD_W-1:0]      rem_reg  [N+1];
    logic [HOLD_W-1:0]      m_reg    [N+1];
    logic [SIDE_W-1:0]      side_reg [N+1];
    logic [63:0]            dvd_next [N+1];
    logic [HOLD_W-1:0]      rem_next [N+1];
    logic                   ov_reg;
    logic [HOLD_W-1:0]      orem_reg;
    logic [SIDE_W-1:0]      oside_reg;

    // restoring remainder steps between stages
    always_comb
    begin
        logic [HOLD_W:0]   t;
        logic [HOLD_W-1:0] r;
        dvd_next[0] = '0;
        rem_next[0] = '0;
        for (int s = 0; s < N; s++)
        begin
            r = rem_reg[s];
            for (int k = 0; k < 2; k++)
            begin
                t = {r, dvd_reg[s][63-k]};
                if (t >= {1'b0, m_reg[s]})
                begin
                    t = t - {1'b0, m_reg[s]};
                end
                r = t[HOLD_W-1:0];
            end
            rem_next[s+1] = r;
            dvd_next[s+1] = {dvd_reg[s][61:0], 2'b00};
        end
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg  <= '0;
            ov_reg <= 1'b0;
        end
        else if (en)
        begin
            v_reg  <= {v_reg[N-1:0], in_valid};
            ov_reg <= v_reg[N];
        end
    end

    // payload stages
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            neg_reg[0]  <= in_a[63];
            dvd_reg[0]  <= in_a[63] ? (64'd0 - in_a) : in_a;
            rem_reg[0]  <= '0;
            m_reg[0]    <= in_m;
            side_reg[0] <= in_side;
            for (int s = 1; s <= N; s++)
            begin
                neg_reg[s]  <= neg_reg[s-1];
                dvd_reg[s]  <= dvd_next[s];
                rem_reg[s]  <= rem_next[s];
                m_reg[s]    <= m_reg[s-1];
                side_reg[s] <= side_reg[s-1];
            end
            orem_reg  <= (neg_reg[N] && rem_reg[N] != '0) ? m_reg[N] - rem_reg[N]
                                                           : rem_reg[N];
            oside_reg <= side_reg[N];
        end
    end

    assign out_valid = ov_reg;
    assign out_rem   = orem_reg;
    assign out_side  = oside_reg;

endmodule

FILE: src/random_hold_value_generator.sv
// Random hold value generator: for each signed 64-bit frame it returns a held
// state, a 53-bit random fraction and the hold length in use. Fully pipelined:
// one frame is taken every cycle while the output is not stalled, and each
// result passes two remainder pipelines, two bits a stage, plus seven stages
// each for the hash and multiply chains. Any output stall freezes the whole
// pipeline. Configuration may be written only while no frame is in flight.
module random_hold_value_generator
    import rhv_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [63:0]         s_tdata,   // frame
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [151:0]        m_tdata,   // held_state, rand_fraction, hold_length
    input  logic                cfg_we,
    input  logic [CFG_AW-1:0]   cfg_addr,
    input  logic [31:0]         cfg_wdata
);

    logic [HOLD_W-1:0] min_reg, max_reg, ival_reg;
    logic [31:0]       sin_reg, sout_reg;
    logic              fen_reg;
    logic              adv;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_reg  <= 32'd12;
            max_reg  <= 32'd21;
            ival_reg <= 32'd7;
            sin_reg  <= 32'hFFFFFFD7;
            sout_reg <= 32'd23;
            fen_reg  <= 1'b1;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                CFG_MIN_HOLD:   min_reg  <= cfg_wdata;
                CFG_MAX_HOLD:   max_reg  <= cfg_wdata;
                CFG_RESEED:     ival_reg <= cfg_wdata;
                CFG_SEED_INNER: sin_reg  <= cfg_wdata;
                CFG_SEED_OUTER: sout_reg <= cfg_wdata;
                CFG_FINAL_EN:   fen_reg  <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    assign adv      = !m_tvalid || m_tready;
    assign s_tready = adv;

    // reseed remainder
    logic              da_v;
    logic [HOLD_W-1:0] da_rem;
    logic [63:0]       da_frame;

    rhv_modpipe #(.SIDE_W(64)) u_mod_a
    (
        .clk(clk), .rst_n(rst_n), .en(adv),
        .in_valid(s_tvalid && s_tready),
        .in_a(s_tdata),
        .in_m((ival_reg == '0) ? HOLD_W'(1) : ival_reg),
        .in_side(s_tdata),
        .out_valid(da_v), .out_rem(da_rem), .out_side(da_frame)
    );

    // hold length draw chain
    logic [6:0]        t_v_reg;
    logic [63:0]       t_fr_reg [6];
    logic [63:0]       t1_reg, t3_reg;
    pp_t               t2_reg, t4_reg;
    logic [FRAC_W-1:0] t5_reg;
    logic [63:0]       t6_lo_reg;
    logic [52:0]       t6_hi_reg;
    logic [HOLD_W-1:0] t7_hold_reg;
    logic [63:0]       t7_outer_reg;

    logic [63:0]  anchor, t1_x, t3_z, t5_z, outer;
    logic [84:0]  prod;
    logic [HOLD_W-1:0] diff, q, hold;
    logic         prod_rem;

    always_comb
    begin
        anchor = {{32{sin_reg[31]}}, sin_reg} + da_frame - 64'(da_rem);
        t1_x   = anchor + MIX_ADD;
        t3_z   = pp_sum(t2_reg);
        t5_z   = pp_sum(t4_reg);
        diff   = (max_reg >= min_reg) ? max_reg - min_reg : min_reg - max_reg;
        prod   = 85'(t6_lo_reg) + {t6_hi_reg, 32'd0};
        q      = prod[84:53];
        prod_rem = prod[52:0] != '0;
        if (max_reg >= min_reg)
        begin
            hold = min_reg + q;
        end
        else
        begin
            hold = min_reg - q - HOLD_W'(prod_rem);
        end
        if (hold == '0)
        begin
            hold = HOLD_W'(1);
        end
        outer = {{32{sout_reg[31]}}, sout_reg} + t_fr_reg[5];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            t_v_reg <= '0;
        end
        else if (adv)
        begin
            t_v_reg <= {t_v_reg[5:0], da_v};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            t_fr_reg[0] <= da_frame;
            for (int s = 1; s < 6; s++)
            begin
                t_fr_reg[s] <= t_fr_reg[s-1];
            end
            t1_reg       <= t1_x ^ (t1_x >> 30);
            t2_reg       <= mul_pp(t1_reg, MIX_MUL1);
            t3_reg       <= t3_z ^ (t3_z >> 27);
            t4_reg       <= mul_pp(t3_reg, MIX_MUL2);
            t5_reg       <= FRAC_W'((t5_z ^ (t5_z >> 31)) >> 11);
            t6_lo_reg    <= 64'(t5_reg[31:0]) * 64'(diff);
            t6_hi_reg    <= 53'(t5_reg[52:32]) * 53'(diff);
            t7_hold_reg  <= hold;
            t7_outer_reg <= outer;
        end
    end

    // hold alignment remainder
    logic              db_v;
    logic [HOLD_W-1:0] db_rem;
    logic [95:0]       db_side;

    rhv_modpipe #(.SIDE_W(96)) u_mod_b
    (
        .clk(clk), .rst_n(rst_n), .en(adv),
        .in_valid(t_v_reg[6]),
        .in_a(t7_outer_reg),
        .in_m(t7_hold_reg),
        .in_side({t7_hold_reg, t7_outer_reg}),
        .out_valid(db_v), .out_rem(db_rem), .out_side(db_side)
    );

    // output hash chain
    logic [6:0]        u_v_reg;
    logic [63:0]       u_held_reg [7];
    logic [HOLD_W-1:0] u_hold_reg [7];
    pp_t               u2_reg, u4_reg, u6_reg;
    logic [63:0]       u3_reg, u5_reg;
    logic [FRAC_W-1:0] u7_reg;
    logic [63:0]       held, u3_m, u5_z, u7_z;

    always_comb
    begin
        held = db_side[63:0] - 64'(db_rem);
        u3_m = pp_sum(u2_reg) + MIX_ADD;
        u5_z = pp_sum(u4_reg);
        u7_z = pp_sum(u6_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            u_v_reg <= '0;
        end
        else if (adv)
        begin
            u_v_reg <= {u_v_reg[5:0], db_v};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            u_held_reg[0] <= held;
            u_hold_reg[0] <= db_side[95:64];
            for (int s = 1; s < 7; s++)
            begin
                u_held_reg[s] <= u_held_reg[s-1];
                u_hold_reg[s] <= u_hold_reg[s-1];
            end
            u2_reg <= mul_pp(u_held_reg[0], HELD_MUL);
            u3_reg <= u3_m ^ (u3_m >> 30);
            u4_reg <= mul_pp(u3_reg, MIX_MUL1);
            u5_reg <= u5_z ^ (u5_z >> 27);
            u6_reg <= mul_pp(u5_reg, MIX_MUL2);
            u7_reg <= fen_reg ? FRAC_W'((u7_z ^ (u7_z >> 31)) >> 11) : '0;
        end
    end

    assign m_tvalid = u_v_reg[6];
    assign m_tdata  = {3'b000, u_hold_reg[6], u7_reg, u_held_reg[6]};

    // checks
    a_hold_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[148:117] != '0)
        else $error("hold length zero");

    a_rem_below: assert property (@(posedge clk) disable iff (!rst_n)
        db_v |-> db_rem < db_side[95:64])
        else $error("alignment remainder not below hold");

    a_frac_off: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !fen_reg && $stable(fen_reg) && $past(adv) |-> m_tdata[116:64] == '0)
        else $error("fraction nonzero while disabled");

endmodule
